### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

### rtl/ekv_pkg.sv
// ----------------------------------------------------------------------------
// Expiring key/value cache package
// Shared widths, command codes, controller states and control/status structs.
// ----------------------------------------------------------------------------
package ekv_pkg;

  localparam int KEY_BITS           = 64;
  localparam int TIME_BITS          = 64;
  localparam int VALUE_PORT_BITS    = 32;
  localparam int SLOT_BITS          = 3;
  localparam int CMD_BITS           = 3;
  localparam int ENTRIES_DEFAULT    = 8;
  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int MAX_RESULTS        = 8;
  localparam int CNT_BITS           = $clog2(MAX_RESULTS);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOOKUP = 3'd0,
    CMD_SET    = 3'd1,
    CMD_RECENT = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_ENUM   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_FINISH,
    ST_RECENT,
    ST_ENUM,
    ST_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_MISS,
    RES_HIT,
    RES_NEW,
    RES_FULL,
    RES_ENTRY,
    RES_PEND
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     load_zero;
    logic     advance;
    logic     track;
    logic     set_value;
    logic     wr_hit;
    logic     wr_spare;
    logic     clear;
    logic     pend_push;
    res_sel_t res_sel;
    logic     res_last;
  } ctl_t;

  typedef struct packed {
    logic live;
    logic hit;
    logic spare_valid;
    logic pend_valid;
  } stat_t;

endpackage

### rtl/ekv_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ekv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ekv_ctrl.sv
// ----------------------------------------------------------------------------
// Expiring key/value cache controller
// Sequences probes, enumeration scans and result emission for each command.
// ----------------------------------------------------------------------------
module ekv_ctrl import ekv_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [CMD_BITS-1:0] command,
  output logic                busy,
  output ctl_t                ctl,
  input  stat_t               stat
);

  localparam int IW = $clog2(ENTRIES);

  state_t                state, state_next;
  logic [IW-1:0]         h, h_next;
  logic [CNT_BITS-1:0]   cnt, cnt_next;
  logic                  is_set, is_set_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      h      <= '0;
      cnt    <= '0;
      is_set <= 1'b0;
    end else begin
      state  <= state_next;
      h      <= h_next;
      cnt    <= cnt_next;
      is_set <= is_set_next;
    end
  end

  always_comb begin
    state_next  = state;
    h_next      = h;
    cnt_next    = cnt;
    is_set_next = is_set;
    ctl         = '0;
    ctl.res_sel = RES_NONE;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (command) inside
            CMD_LOOKUP, CMD_SET: begin
              ctl.load    = 1'b1;
              is_set_next = (command == CMD_SET);
              h_next      = '0;
              state_next  = ST_PROBE;
            end
            CMD_RECENT: begin
              ctl.load   = 1'b1;
              state_next = ST_RECENT;
            end
            CMD_CLEAR: begin
              ctl.clear = 1'b1;
            end
            CMD_ENUM: begin
              ctl.load_zero = 1'b1;
              h_next        = '0;
              cnt_next      = '0;
              state_next    = ST_ENUM;
            end
            default: ;
          endcase
        end
      end
      ST_PROBE: begin
        ctl.set_value = is_set;
        if (stat.hit) begin
          ctl.wr_hit   = 1'b1;
          ctl.res_sel  = RES_HIT;
          ctl.res_last = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          ctl.track   = 1'b1;
          ctl.advance = 1'b1;
          if (h == IW'(ENTRIES - 1)) begin
            state_next = ST_FINISH;
          end else begin
            h_next = h + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        ctl.res_last = 1'b1;
        state_next   = ST_IDLE;
        if (!is_set) begin
          ctl.res_sel = RES_MISS;
        end else if (stat.spare_valid) begin
          ctl.wr_spare = 1'b1;
          ctl.res_sel  = RES_NEW;
        end else begin
          ctl.res_sel = RES_FULL;
        end
      end
      ST_RECENT: begin
        ctl.res_sel  = stat.live ? RES_ENTRY : RES_MISS;
        ctl.res_last = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_ENUM: begin
        ctl.advance = 1'b1;
        if (h != IW'(ENTRIES - 1)) begin
          h_next = h + 1'b1;
        end else begin
          state_next = ST_FLUSH;
        end
        if (stat.live) begin
          ctl.pend_push = 1'b1;
          if (stat.pend_valid) begin
            ctl.res_sel = RES_PEND;
          end
          if (cnt == CNT_BITS'(MAX_RESULTS - 1)) begin
            state_next = ST_FLUSH;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (stat.pend_valid) begin
          ctl.res_sel  = RES_PEND;
          ctl.res_last = 1'b1;
        end
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

### rtl/ekv_dp.sv
// ----------------------------------------------------------------------------
// Expiring key/value cache datapath
// Entry RAM, used bits, probe pointer, spare tracking and result registers.
// ----------------------------------------------------------------------------
module ekv_dp import ekv_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEFAULT,
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [TIME_BITS-1:0]       cfg_wdata,
  input  logic [KEY_BITS-1:0]        key,
  input  logic [VALUE_PORT_BITS-1:0] value,
  input  logic [TIME_BITS-1:0]       now,
  input  ctl_t                       ctl,
  output stat_t                      stat,
  output logic                       strobe,
  output logic                       found,
  output logic                       created,
  output logic                       full_res,
  output logic [KEY_BITS-1:0]        key_out,
  output logic [VALUE_PORT_BITS-1:0] value_out,
  output logic [SLOT_BITS-1:0]       slot,
  output logic                       last
);

  localparam int IW = $clog2(ENTRIES);
  localparam int WW = KEY_BITS + TIME_BITS + VALUE_BITS;

  logic [TIME_BITS-1:0]  lifetime;
  logic [ENTRIES-1:0]    used;
  logic [IW-1:0]         ptr, ptr_next;
  logic [IW-1:0]         recent;
  logic [IW-1:0]         spare;
  logic                  spare_valid;
  logic                  pend_valid;
  logic [KEY_BITS-1:0]   pend_key;
  logic [VALUE_BITS-1:0] pend_val;
  logic [IW-1:0]         pend_slot;
  logic [KEY_BITS-1:0]   key_r;
  logic [TIME_BITS-1:0]  now_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_in;

  logic [WW-1:0]         rd_word;
  logic [KEY_BITS-1:0]   rd_key;
  logic [TIME_BITS-1:0]  rd_stamp;
  logic [VALUE_BITS-1:0] rd_val;
  logic [TIME_BITS-1:0]  age;
  logic                  live;
  logic                  hit;
  logic [VALUE_BITS-1:0] new_val;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [WW-1:0]         ram_wdata;

  logic                  r_found;
  logic                  r_created;
  logic                  r_full;
  logic [KEY_BITS-1:0]   r_key;
  logic [VALUE_BITS-1:0] r_val;
  logic [IW-1:0]         r_idx;
  logic [VALUE_PORT_BITS-1:0] r_val32;
  logic [SLOT_BITS-1:0]  r_slot;

  for (genvar b = 0; b < VALUE_BITS; b++) begin : g_vin
    if (b < VALUE_PORT_BITS) begin : g_bit
      assign val_in[b] = value[b];
    end else begin : g_zero
      assign val_in[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < VALUE_PORT_BITS; b++) begin : g_vout
    if (b < VALUE_BITS) begin : g_bit
      assign r_val32[b] = r_val[b];
    end else begin : g_zero
      assign r_val32[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < SLOT_BITS; b++) begin : g_slot
    if (b < IW) begin : g_bit
      assign r_slot[b] = r_idx[b];
    end else begin : g_zero
      assign r_slot[b] = 1'b0;
    end
  end

  ekv_ram #(
    .WIDTH (WW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_next),
    .rdata (rd_word)
  );

  assign rd_key   = rd_word[WW-1 -: KEY_BITS];
  assign rd_stamp = rd_word[VALUE_BITS +: TIME_BITS];
  assign rd_val   = rd_word[VALUE_BITS-1:0];

  assign age     = now_r - rd_stamp;
  assign live    = used[ptr] && (age < lifetime);
  assign hit     = live && (rd_key == key_r);
  assign new_val = ctl.set_value ? val_r : rd_val;

  assign stat.live        = live;
  assign stat.hit         = hit;
  assign stat.spare_valid = spare_valid;
  assign stat.pend_valid  = pend_valid;

  assign ram_we    = ctl.wr_hit || ctl.wr_spare;
  assign ram_waddr = ctl.wr_spare ? spare : ptr;
  assign ram_wdata = {key_r, now_r, (ctl.wr_spare ? val_r : new_val)};

  always_comb begin
    ptr_next = ptr;
    if (ctl.load) begin
      ptr_next = recent;
    end else if (ctl.load_zero) begin
      ptr_next = '0;
    end else if (ctl.advance) begin
      ptr_next = (ptr == IW'(ENTRIES - 1)) ? '0 : ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime    <= '0;
      used        <= '0;
      ptr         <= '0;
      recent      <= '0;
      spare_valid <= 1'b0;
      pend_valid  <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      if (cfg_we) begin
        lifetime <= cfg_wdata;
      end
      ptr <= ptr_next;
      if (ctl.clear) begin
        used <= '0;
      end else if (ctl.wr_spare) begin
        used[spare] <= 1'b1;
      end
      if (ctl.wr_hit) begin
        recent <= ptr;
      end else if (ctl.wr_spare) begin
        recent <= spare;
      end
      if (ctl.load || ctl.load_zero) begin
        spare_valid <= 1'b0;
      end else if (ctl.track && (!used[ptr] || (!live && !spare_valid))) begin
        spare_valid <= 1'b1;
      end
      if (ctl.load || ctl.load_zero) begin
        pend_valid <= 1'b0;
      end else if (ctl.pend_push) begin
        pend_valid <= 1'b1;
      end
      strobe <= (ctl.res_sel != RES_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load || ctl.load_zero) begin
      key_r <= key;
      now_r <= now;
      val_r <= val_in;
    end
    if (ctl.track && (!used[ptr] || (!live && !spare_valid))) begin
      spare <= ptr;
    end
    if (ctl.pend_push) begin
      pend_key  <= rd_key;
      pend_val  <= rd_val;
      pend_slot <= ptr;
    end
  end

  always_comb begin
    r_found   = 1'b0;
    r_created = 1'b0;
    r_full    = 1'b0;
    r_key     = '0;
    r_val     = '0;
    r_idx     = '0;
    case (ctl.res_sel)
      RES_HIT: begin
        r_found = 1'b1;
        r_key   = key_r;
        r_val   = new_val;
        r_idx   = ptr;
      end
      RES_NEW: begin
        r_created = 1'b1;
        r_key     = key_r;
        r_val     = val_r;
        r_idx     = spare;
      end
      RES_FULL: begin
        r_full = 1'b1;
        r_key  = key_r;
        r_val  = val_r;
      end
      RES_ENTRY: begin
        r_found = 1'b1;
        r_key   = rd_key;
        r_val   = rd_val;
        r_idx   = ptr;
      end
      RES_PEND: begin
        r_found = 1'b1;
        r_key   = pend_key;
        r_val   = pend_val;
        r_idx   = pend_slot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.res_sel != RES_NONE) begin
      found     <= r_found;
      created   <= r_created;
      full_res  <= r_full;
      key_out   <= r_key;
      value_out <= r_val32;
      slot      <= r_slot;
      last      <= ctl.res_last;
    end
  end

endmodule

### rtl/expiring_key_value_cache.sv
// ----------------------------------------------------------------------------
// Expiring key/value cache
// Small key/value table whose entries expire a set number of ticks after
// their last lookup or set; lookup, set, get-recent, clear-all and enumerate.
// ----------------------------------------------------------------------------
// Raise start with command, key, value and now while busy is low; the item is
// taken on that edge. Each result is marked by strobe, high for a single cycle,
// stays on the result ports until the next result and cannot be held off.
// Lookup and set probe one entry per cycle from the most recently used slot
// through the entry RAM read port; busy falls on the same edge that presents
// the result. Get-recent answers with the most recently used slot while it is
// live and with a miss otherwise, clear-all completes on the accepting edge
// with no result, and enumerate scans the slots one per cycle from slot 0
// until it has found eight live entries or passed the last slot. Write
// lifetime with cfg_we only while idle.
module expiring_key_value_cache import ekv_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEFAULT,
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [TIME_BITS-1:0]       cfg_wdata,
  input  logic                       start,
  output logic                       busy,
  input  logic [CMD_BITS-1:0]        command,
  input  logic [KEY_BITS-1:0]        key,
  input  logic [VALUE_PORT_BITS-1:0] value,
  input  logic [TIME_BITS-1:0]       now,
  output logic                       strobe,
  output logic                       found,
  output logic                       created,
  output logic                       full_res,
  output logic [KEY_BITS-1:0]        key_out,
  output logic [VALUE_PORT_BITS-1:0] value_out,
  output logic [SLOT_BITS-1:0]       slot,
  output logic                       last
);

`include "assert_macros.svh"

  ctl_t  ctl;
  stat_t stat;

  ekv_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .busy    (busy),
    .ctl     (ctl),
    .stat    (stat)
  );

  ekv_dp #(
    .ENTRIES    (ENTRIES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .key       (key),
    .value     (value),
    .now       (now),
    .ctl       (ctl),
    .stat      (stat),
    .strobe    (strobe),
    .found     (found),
    .created   (created),
    .full_res  (full_res),
    .key_out   (key_out),
    .value_out (value_out),
    .slot      (slot),
    .last      (last)
  );

  `ASSERT_PROP(a_strobe_from_busy, clk, rst, strobe |-> $past(busy), "result outside a run")
  `ASSERT_PROP(a_no_result_on_accept, clk, rst, (start && !busy) |=> !strobe, "result on accept")
  `ASSERT_NEVER(a_single_write, clk, rst, ctl.wr_hit && ctl.wr_spare, "two entry writes at once")

endmodule

### verif/expiring_key_value_cache_tb.sv
// ----------------------------------------------------------------------------
// Expiring key/value cache testbench
// Drives lookup, set, get-recent, clear-all and enumerate commands through
// the start/busy handshake under several lifetimes and sender idle rates. A
// shadow copy of the table predicts every strobed response, and each one is
// compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module expiring_key_value_cache_tb;
  import ekv_pkg::*;

  localparam int NUM_SLOTS = ENTRIES_DEFAULT;
  localparam int POOL_KEYS = 10;
  localparam int PHASES    = 5;
  localparam int PHASE_CMDS = 96;

  typedef struct packed {
    logic                       found;
    logic                       created;
    logic                       full_res;
    logic [KEY_BITS-1:0]        key_out;
    logic [VALUE_PORT_BITS-1:0] value_out;
    logic [SLOT_BITS-1:0]       slot;
    logic                       last;
  } cache_resp_t;

  class cache_scoreboard;
    logic [TIME_BITS-1:0]       lifetime;
    logic [KEY_BITS-1:0]        slot_key[NUM_SLOTS];
    logic [TIME_BITS-1:0]       slot_stamp[NUM_SLOTS];
    logic [VALUE_PORT_BITS-1:0] slot_value[NUM_SLOTS];
    bit                         slot_used[NUM_SLOTS];
    int                         recent;
    cache_resp_t                expected_resps[$];
    int mismatches;
    int resps_checked;
    int hits;
    int creates;
    int fulls;

    function new();
      lifetime = '0;
      recent = 0;
      foreach (slot_used[j]) begin
        slot_used[j] = 0;
        slot_key[j] = '0;
        slot_stamp[j] = '0;
        slot_value[j] = '0;
      end
      mismatches = 0;
      resps_checked = 0;
      hits = 0;
      creates = 0;
      fulls = 0;
    endfunction

    function bit is_live(int j, logic [TIME_BITS-1:0] t);
      logic [TIME_BITS-1:0] age;
      age = t - slot_stamp[j];
      return slot_used[j] && (age < lifetime);
    endfunction

    function void push_resp(bit f, bit c, bit fl, logic [KEY_BITS-1:0] k,
                            logic [VALUE_PORT_BITS-1:0] v, int s, bit l);
      cache_resp_t r;
      r.found = f;
      r.created = c;
      r.full_res = fl;
      r.key_out = k;
      r.value_out = v;
      r.slot = SLOT_BITS'(s);
      r.last = l;
      expected_resps.push_back(r);
    endfunction

    function void predict_command(cmd_t cmd, logic [KEY_BITS-1:0] k,
                                  logic [VALUE_PORT_BITS-1:0] v,
                                  logic [TIME_BITS-1:0] t);
      int spare;
      int i;
      int n;
      case (cmd)
        CMD_LOOKUP, CMD_SET: begin
          spare = -1;
          for (int h = 0; h < NUM_SLOTS; h++) begin
            i = (recent + h) % NUM_SLOTS;
            if (!slot_used[i]) begin
              spare = i;
            end else if (!is_live(i, t)) begin
              if (spare < 0) spare = i;
            end else if (slot_key[i] == k) begin
              slot_stamp[i] = t;
              recent = i;
              if (cmd == CMD_SET) slot_value[i] = v;
              push_resp(1, 0, 0, k, slot_value[i], i, 1);
              hits++;
              return;
            end
          end
          if (cmd == CMD_LOOKUP) begin
            push_resp(0, 0, 0, '0, '0, 0, 1);
          end else if (spare < 0) begin
            push_resp(0, 0, 1, k, v, 0, 1);
            fulls++;
          end else begin
            slot_key[spare] = k;
            slot_value[spare] = v;
            slot_stamp[spare] = t;
            slot_used[spare] = 1;
            recent = spare;
            push_resp(0, 1, 0, k, v, spare, 1);
            creates++;
          end
        end
        CMD_RECENT: begin
          if (is_live(recent, t))
            push_resp(1, 0, 0, slot_key[recent], slot_value[recent], recent, 1);
          else
            push_resp(0, 0, 0, '0, '0, 0, 1);
        end
        CMD_CLEAR: begin
          foreach (slot_used[j]) slot_used[j] = 0;
        end
        CMD_ENUM: begin
          n = 0;
          for (int j = 0; j < NUM_SLOTS && n < MAX_RESULTS; j++) begin
            if (is_live(j, t)) begin
              push_resp(1, 0, 0, slot_key[j], slot_value[j], j, 0);
              n++;
            end
          end
          if (n > 0) expected_resps[expected_resps.size() - 1].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void check_response(cache_resp_t got);
      cache_resp_t want;
      resps_checked++;
      if (expected_resps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected response: found=%0b created=%0b full=%0b key=%h value=%h slot=%0d last=%0b",
                   $realtime, got.found, got.created, got.full_res, got.key_out,
                   got.value_out, got.slot, got.last);
        return;
      end
      want = expected_resps.pop_front();
      if (got.found !== want.found || got.created !== want.created ||
          got.full_res !== want.full_res || got.key_out !== want.key_out ||
          got.value_out !== want.value_out || got.slot !== want.slot ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] response mismatch", $realtime);
          $display("  expected: found=%0b created=%0b full=%0b key=%h value=%h slot=%0d last=%0b",
                   want.found, want.created, want.full_res, want.key_out,
                   want.value_out, want.slot, want.last);
          $display("  actual:   found=%0b created=%0b full=%0b key=%h value=%h slot=%0d last=%0b",
                   got.found, got.created, got.full_res, got.key_out,
                   got.value_out, got.slot, got.last);
        end
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [TIME_BITS-1:0]       cfg_wdata;
  logic                       start;
  logic                       busy;
  logic [CMD_BITS-1:0]        command;
  logic [KEY_BITS-1:0]        key;
  logic [VALUE_PORT_BITS-1:0] value;
  logic [TIME_BITS-1:0]       now;
  logic                       strobe;
  logic                       found;
  logic                       created;
  logic                       full_res;
  logic [KEY_BITS-1:0]        key_out;
  logic [VALUE_PORT_BITS-1:0] value_out;
  logic [SLOT_BITS-1:0]       slot;
  logic                       last;

  cache_scoreboard      sb;
  int                   cmds_accepted;
  logic [TIME_BITS-1:0] cur_time;
  logic [KEY_BITS-1:0]  key_pool[POOL_KEYS];
  logic [TIME_BITS-1:0] phase_lifetime[PHASES];
  int                   phase_idle_pct[PHASES];

  expiring_key_value_cache u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .start    (start),
    .busy     (busy),
    .command  (command),
    .key      (key),
    .value    (value),
    .now      (now),
    .strobe   (strobe),
    .found    (found),
    .created  (created),
    .full_res (full_res),
    .key_out  (key_out),
    .value_out(value_out),
    .slot     (slot),
    .last     (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("expiring_key_value_cache_tb failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe)
        sb.check_response({found, created, full_res, key_out, value_out, slot, last});
      if (start && !busy) begin
        sb.predict_command(cmd_t'(command), key, value, now);
        cmds_accepted++;
      end
    end
  end

  task automatic send_cmd(cmd_t cmd, logic [KEY_BITS-1:0] k,
                          logic [VALUE_PORT_BITS-1:0] v, logic [TIME_BITS-1:0] t);
    int seen;
    seen = cmds_accepted;
    command = cmd;
    key = k;
    value = v;
    now = t;
    start = 1'b1;
    do @(negedge clk); while (cmds_accepted == seen);
  endtask

  task automatic drain();
    start = 1'b0;
    while (sb.expected_resps.size() != 0 || busy) @(negedge clk);
    repeat (NUM_SLOTS + 4) @(negedge clk);
  endtask

  task automatic write_lifetime(logic [TIME_BITS-1:0] v);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.lifetime = v;
  endtask

  task automatic run_directed();
    logic [TIME_BITS-1:0] t0;
    t0 = 64'd1000;
    send_cmd(CMD_LOOKUP, '0, '0, t0);
    send_cmd(CMD_RECENT, '0, '0, t0);
    send_cmd(CMD_ENUM, '0, '0, t0);
    send_cmd(CMD_SET, '0, '0, t0);
    send_cmd(CMD_SET, '1, '1, t0 + 1);
    send_cmd(CMD_LOOKUP, '1, '0, t0 + 2);
    send_cmd(CMD_SET, '0, 32'h5a5a_a5a5, t0 + 3);
    send_cmd(CMD_RECENT, '0, '0, t0 + 3);
    send_cmd(CMD_ENUM, '0, '0, t0 + 3);
    for (int j = 0; j < NUM_SLOTS - 2; j++)
      send_cmd(CMD_SET, {$urandom, $urandom}, $urandom, t0 + 4);
    send_cmd(CMD_SET, 64'h0123_4567_89ab_cdef, 32'hdead_beef, t0 + 5);
    send_cmd(CMD_ENUM, '0, '0, t0 + 5);
    send_cmd(CMD_SET, 64'hfeed_0000_0000_feed, 32'h1234_5678, t0 + 200);
    send_cmd(CMD_LOOKUP, '1, '0, t0 + 200);
    send_cmd(CMD_CLEAR, '0, '0, t0 + 200);
    send_cmd(CMD_LOOKUP, 64'hfeed_0000_0000_feed, '0, t0 + 200);
    send_cmd(CMD_SET, 64'hcafe_f00d_cafe_f00d, 32'h8000_0001, '1);
    send_cmd(CMD_LOOKUP, 64'hcafe_f00d_cafe_f00d, '0, 64'd5);
    cur_time = 64'd5;
  endtask

  function automatic cmd_t pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 32) return CMD_SET;
    if (r < 62) return CMD_LOOKUP;
    if (r < 74) return CMD_RECENT;
    if (r < 94) return CMD_ENUM;
    return CMD_CLEAR;
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, POOL_KEYS - 1)];
  endfunction

  task automatic advance_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return;
    if (r < 90) cur_time += $urandom_range(1, 4);
    else if (r < 98) cur_time += $urandom_range(5, 80);
    else cur_time = {$urandom, $urandom};
  endtask

  task automatic run_phase(int idle_pct);
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int j = 2; j < POOL_KEYS; j++) key_pool[j] = {$urandom, $urandom};
    for (int n = 0; n < PHASE_CMDS; n++) begin
      if (n == PHASE_CMDS / 2) drain();
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        start = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      advance_time();
      send_cmd(pick_command(), pick_key(), $urandom, cur_time);
    end
  endtask

  initial begin
    sb = new();
    cmds_accepted = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    command = CMD_LOOKUP;
    key = '0;
    value = '0;
    now = '0;
    cur_time = '0;
    phase_lifetime = '{64'd40, '1, 64'd0, 64'd1, 64'd12};
    phase_idle_pct = '{0, 54, 23, 0, 54};
    repeat (12) @(negedge clk);
    rst = 1'b0;
    write_lifetime(64'd100);
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_lifetime(phase_lifetime[p]);
      run_phase(phase_idle_pct[p]);
    end
    drain();
    $display("covered %0d command transfers and %0d responses: %0d hits, %0d new entries, %0d full reports over %0d lifetimes",
             cmds_accepted, sb.resps_checked, sb.hits, sb.creates, sb.fulls, PHASES + 1);
    if (sb.mismatches == 0) begin
      $display("expiring_key_value_cache_tb passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("expiring_key_value_cache_tb failed");
    end
    $finish;
  end

endmodule
